@@ hdl/least_loaded_connection_table_assert.svh @@
// Assertion macros used by least_loaded_connection_table.sv
`ifndef LEAST_LOADED_CONNECTION_TABLE_ASSERT_SVH
`define LEAST_LOADED_CONNECTION_TABLE_ASSERT_SVH

// Implication checked on every clock, quiet during reset
`define LLCT_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Plain invariant checked on every clock, quiet during reset
`define LLCT_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

@@ hdl/llct_pkg.sv @@
`timescale 1ns / 1ps
package llct_pkg;

    // Operation codes of the input action field
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SET    = 2'd2;
    localparam logic [1:0] ACT_SWEEP  = 2'd3;

    // Result codes
    localparam logic [1:0] CODE_OK       = 2'd0;
    localparam logic [1:0] CODE_MISS     = 2'd1;
    localparam logic [1:0] CODE_REJECTED = 2'd2;
    localparam logic [1:0] CODE_TIMEOUT  = 2'd3;

    // Slot status values
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_WORKERS = 2'd0;
    localparam logic [1:0] CFG_SLOTS   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam int LOAD_W = 5;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // Result item
    typedef struct packed {
        logic        last;
        logic [15:0] closed_socket;
        logic [3:0]  slot_index;
        logic [2:0]  chosen_worker;
        logic [1:0]  code;
    } result_t;

endpackage

@@ hdl/llct_ram.sv @@
`timescale 1ns / 1ps
module llct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/least_loaded_connection_table.sv @@
`timescale 1ns / 1ps
// Operation: an add first compares the worker loads to pick the least loaded worker;
// remove, set and sweep use the given worker. Then the slots of that worker are read and
// compared in turn, a matching slot is updated unless an add is rejected, and a result is
// emitted, held by any output stall. Flow: one transaction at a time; the next is accepted
// in the cycle after the last result. A sweep emits one result per closed slot and then a marker.
// Reset: after aresetn the block clears every slot entry, one per cycle, taking no input
// then; loads clear at once, registers return to 8, 16, 15.
module least_loaded_connection_table #(
    parameter int WORKERS = 8,
    parameter int SLOTS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input: tdata = action[1:0], worker[4:2], socket[20:5], new_status[22:21],
    //        admit_reject[23], now[55:24]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // result: tdata = code[1:0], chosen_worker[4:2], slot_index[8:5],
    //         closed_socket[24:9], zero fill [31:25]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import llct_pkg::*;

    localparam int WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH = WORKERS * SLOTS;
    localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W = 2 + 16 + 32;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIN, S_RD, S_CHK, S_WR, S_EMIT, S_WAIT
    } state_t;

    state_t state_reg;
    logic [3:0]  workers_reg;
    logic [4:0]  slots_reg;
    logic [31:0] timeout_reg;
    logic [LOAD_W-1:0] load_reg [WORKERS];

    logic [1:0]  act_reg;
    logic [2:0]  worker_in_reg;
    logic [15:0] sock_reg;
    logic [1:0]  nst_reg;
    logic        rej_reg;
    logic [31:0] now_reg;
    logic [6:0]  widx_reg;   // worker in work (also min search index)
    logic [6:0]  sidx_reg;
    logic [WB-1:0] best_reg;
    logic        done_reg;   // last result of transaction after emit
    logic [AB:0] clr_reg;

    result_t out_reg;
    logic    out_valid_reg;

    // entry memory: {arrival, socket, status}
    logic            ram_we;
    logic [AB-1:0]   ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    llct_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .aclk (aclk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
        .raddr (ram_raddr), .rdata (ram_rdata)
    );

    // clamped register values
    logic [6:0] eff_w, eff_s;
    always_comb begin
        eff_w = (workers_reg == 4'd0) ? 7'd1 :
                ({3'd0, workers_reg} > 7'(WORKERS)) ? 7'(WORKERS) : {3'd0, workers_reg};
        eff_s = (slots_reg == 5'd0) ? 7'd1 :
                ({2'd0, slots_reg} > 7'(SLOTS)) ? 7'(SLOTS) : {2'd0, slots_reg};
    end

    logic [1:0]  e_st;
    logic [15:0] e_sock;
    logic [31:0] e_arr;
    assign e_st   = ram_rdata[1:0];
    assign e_sock = ram_rdata[17:2];
    assign e_arr  = ram_rdata[49:18];

    logic [AB-1:0] cur_addr;
    assign cur_addr = AB'(widx_reg[WB-1:0] * SLOTS + sidx_reg[SB-1:0]);
    assign ram_raddr = cur_addr;

    logic worker_ok;
    assign worker_ok = widx_reg < 7'(WORKERS);

    // slot match for current entry
    logic hit, timed;
    always_comb begin
        hit = 1'b0;
        timed = (now_reg - e_arr) >= timeout_reg;
        case (act_reg)
            ACT_ADD: hit = (e_st == ST_FREE);
            ACT_REMOVE, ACT_SET: hit = (e_st != ST_FREE) && (e_sock == sock_reg);
            ACT_SWEEP: hit = (e_st == ST_PENDING) && timed;
            default: hit = 1'b0;
        endcase
    end

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = ram_rdata;
        if (state_reg == S_CLEAR) begin
            ram_we = 1'b1;
            ram_waddr = clr_reg[AB-1:0];
            ram_wdata = '0;
        end else if (state_reg == S_WR) begin
            ram_we = 1'b1;
            case (act_reg)
                ACT_ADD: ram_wdata = {now_reg, sock_reg, ST_PENDING};
                ACT_SET: ram_wdata = {e_arr, e_sock, nst_reg};
                default: ram_wdata = {e_arr, e_sock, ST_FREE};
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.closed_socket, out_reg.slot_index,
                       out_reg.chosen_worker, out_reg.code};
    assign m_tlast  = out_reg.last;

    function automatic result_t mk(input logic [1:0] c, input logic [6:0] w,
                                   input logic [6:0] s, input logic [15:0] k,
                                   input logic l);
        result_t r;
        r.code = c;
        r.chosen_worker = w[2:0];
        r.slot_index = s[3:0];
        r.closed_socket = k;
        r.last = l;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            workers_reg <= 4'd8;
            slots_reg <= 5'd16;
            timeout_reg <= 32'd15;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WORKERS; i++) begin
                load_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WORKERS: workers_reg <= cfg_wdata[3:0];
                    CFG_SLOTS:   slots_reg <= cfg_wdata[4:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AB+1)'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg <= s_tdata[1:0];
                        worker_in_reg <= s_tdata[4:2];
                        sock_reg <= s_tdata[20:5];
                        nst_reg <= s_tdata[22:21];
                        rej_reg <= s_tdata[23];
                        now_reg <= s_tdata[55:24];
                        sidx_reg <= '0;
                        best_reg <= '0;
                        if (s_tdata[1:0] == ACT_ADD) begin
                            widx_reg <= 7'd1;
                            state_reg <= S_MIN;
                        end else begin
                            widx_reg <= {4'd0, s_tdata[4:2]};
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MIN: begin
                    // one load compared per cycle
                    if (widx_reg >= eff_w) begin
                        widx_reg <= 7'(best_reg);
                        state_reg <= S_RD;
                    end else begin
                        if (load_reg[widx_reg[WB-1:0]] < load_reg[best_reg]) begin
                            best_reg <= widx_reg[WB-1:0];
                        end
                        widx_reg <= widx_reg + 7'd1;
                    end
                end
                S_RD: begin
                    if (!worker_ok || sidx_reg >= eff_s) begin
                        // scan finished without hit
                        done_reg <= 1'b1;
                        if (act_reg == ACT_SWEEP) begin
                            out_reg <= mk(CODE_OK, {4'd0, worker_in_reg}, 7'd0, 16'd0, 1'b1);
                        end else begin
                            out_reg <= mk(CODE_MISS, widx_reg, 7'd0, sock_reg, 1'b1);
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (hit) begin
                        if (act_reg == ACT_ADD && rej_reg) begin
                            out_reg <= mk(CODE_REJECTED, widx_reg, sidx_reg, sock_reg, 1'b1);
                            done_reg <= 1'b1;
                            state_reg <= S_EMIT;
                        end else begin
                            state_reg <= S_WR;
                        end
                    end else begin
                        sidx_reg <= sidx_reg + 7'd1;
                        state_reg <= S_RD;
                    end
                end
                S_WR: begin
                    case (act_reg)
                        ACT_ADD: begin
                            if (load_reg[widx_reg[WB-1:0]] != LOAD_MAX) begin
                                load_reg[widx_reg[WB-1:0]] <= load_reg[widx_reg[WB-1:0]] + 1'b1;
                            end
                            out_reg <= mk(CODE_OK, widx_reg, sidx_reg, sock_reg, 1'b1);
                            done_reg <= 1'b1;
                        end
                        ACT_SET: begin
                            out_reg <= mk(CODE_OK, widx_reg, sidx_reg, sock_reg, 1'b1);
                            done_reg <= 1'b1;
                        end
                        ACT_REMOVE: begin
                            if (load_reg[widx_reg[WB-1:0]] != '0) begin
                                load_reg[widx_reg[WB-1:0]] <= load_reg[widx_reg[WB-1:0]] - 1'b1;
                            end
                            out_reg <= mk(CODE_OK, widx_reg, sidx_reg, sock_reg, 1'b1);
                            done_reg <= 1'b1;
                        end
                        default: begin
                            if (load_reg[widx_reg[WB-1:0]] != '0) begin
                                load_reg[widx_reg[WB-1:0]] <= load_reg[widx_reg[WB-1:0]] - 1'b1;
                            end
                            out_reg <= mk(CODE_TIMEOUT, widx_reg, sidx_reg, e_sock, 1'b0);
                            done_reg <= 1'b0;
                        end
                    endcase
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_tready) begin
                        if (done_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            sidx_reg <= sidx_reg + 7'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "least_loaded_connection_table_assert.svh"

    `LLCT_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready, "accept while busy")
    `LLCT_ASSERT_IMPL(a_wait_valid, aclk, aresetn, state_reg == S_WAIT, m_tvalid, "wait without result")
    `LLCT_ASSERT_IMPL(a_no_write_idle, aclk, aresetn, state_reg == S_IDLE, !ram_we, "write while idle")
    `LLCT_ASSERT_ALWAYS(a_valid_only_wait, aclk, aresetn, !m_tvalid || state_reg == S_WAIT, "stray result")

endmodule

@@ test/least_loaded_connection_table_tb.sv @@
`timescale 1ns / 1ps
module least_loaded_connection_table_tb;
    import llct_pkg::*;

    localparam int NW = 8;
    localparam int NS = 16;
    localparam int SETTLE_CYCLES = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_WORKERS;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Mirror of the connection table
    logic [1:0]  slot_state [NW][NS];
    logic [15:0] slot_sock  [NW][NS];
    logic [31:0] slot_stamp [NW][NS];
    logic [4:0]  load_count [NW];
    logic [3:0]  reg_workers;
    logic [4:0]  reg_slots;
    logic [31:0] reg_timeout;

    result_t     expected_results [$];
    int          fails = 0;
    bit          quiet = 1'b0;
    bit          hold_go = 1'b0;
    logic [31:0] clock_now = 32'd1000;

    least_loaded_connection_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #5ms;
        $display("least_loaded_connection_table test failed");
        $finish;
    end

    function automatic void push_result(logic [1:0] code, logic [2:0] w, logic [3:0] slot,
                                        logic [15:0] sock, logic last);
        result_t r;
        r.code = code;
        r.chosen_worker = w;
        r.slot_index = slot;
        r.closed_socket = sock;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic int active_workers();
        if (reg_workers < 1) return 1;
        if (reg_workers > NW) return NW;
        return reg_workers;
    endfunction

    function automatic int active_slots();
        if (reg_slots < 1) return 1;
        if (reg_slots > NS) return NS;
        return reg_slots;
    endfunction

    // Predict the results of one accepted transaction and update the table
    function automatic void table_step(logic [1:0] act, logic [2:0] w, logic [15:0] sock,
                                       logic [1:0] nst, logic rej, logic [31:0] now);
        int nw, ns, t, hit;
        logic [31:0] age;
        nw = active_workers();
        ns = active_slots();
        hit = -1;
        case (act)
            ACT_ADD: begin
                t = 0;
                for (int i = 1; i < nw; i++)
                    if (load_count[i] < load_count[t]) t = i;
                for (int i = 0; i < ns; i++)
                    if (hit < 0 && slot_state[t][i] == ST_FREE) hit = i;
                if (hit < 0) begin
                    push_result(CODE_MISS, 3'(t), 4'd0, sock, 1'b1);
                end else if (rej) begin
                    push_result(CODE_REJECTED, 3'(t), 4'(hit), sock, 1'b1);
                end else begin
                    if (load_count[t] < LOAD_MAX) load_count[t]++;
                    slot_state[t][hit] = ST_PENDING;
                    slot_sock[t][hit] = sock;
                    slot_stamp[t][hit] = now;
                    push_result(CODE_OK, 3'(t), 4'(hit), sock, 1'b1);
                end
            end
            ACT_REMOVE, ACT_SET: begin
                for (int i = 0; i < ns; i++)
                    if (hit < 0 && slot_state[w][i] != ST_FREE && slot_sock[w][i] == sock)
                        hit = i;
                if (hit < 0) begin
                    push_result(CODE_MISS, w, 4'd0, sock, 1'b1);
                end else begin
                    if (act == ACT_REMOVE) begin
                        if (load_count[w] > 0) load_count[w]--;
                        slot_state[w][hit] = ST_FREE;
                    end else begin
                        slot_state[w][hit] = nst;
                    end
                    push_result(CODE_OK, w, 4'(hit), sock, 1'b1);
                end
            end
            default: begin
                for (int i = 0; i < ns; i++) begin
                    age = now - slot_stamp[w][i];
                    if (slot_state[w][i] == ST_PENDING && age >= reg_timeout) begin
                        if (load_count[w] > 0) load_count[w]--;
                        slot_state[w][i] = ST_FREE;
                        push_result(CODE_TIMEOUT, w, 4'(i), slot_sock[w][i], 1'b0);
                    end
                end
                push_result(CODE_OK, w, 4'd0, 16'h0000, 1'b1);
            end
        endcase
    endfunction

    // Result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_tdata);
                fails++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.code) begin
                    $error("code: expected %0d, got %0d", want.code, m_tdata[1:0]);
                    fails++;
                end
                if (m_tdata[4:2] !== want.chosen_worker) begin
                    $error("chosen_worker: expected %0d, got %0d", want.chosen_worker,
                           m_tdata[4:2]);
                    fails++;
                end
                if (m_tdata[8:5] !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index, m_tdata[8:5]);
                    fails++;
                end
                if (m_tdata[24:9] !== want.closed_socket) begin
                    $error("closed_socket: expected %h, got %h", want.closed_socket,
                           m_tdata[24:9]);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one transaction; called and returns at a falling edge
    task automatic send_op(logic [1:0] act, logic [2:0] w, logic [15:0] sock,
                           logic [1:0] nst, logic rej, logic [31:0] now);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, rej, nst, sock, w, act};
        do @(posedge aclk); while (!s_tready);
        table_step(act, w, sock, nst, rej, now);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_WORKERS: reg_workers = value[3:0];
            CFG_SLOTS:   reg_slots = value[4:0];
            default:     reg_timeout = value;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(logic [31:0] workers, logic [31:0] slots, logic [31:0] timeout);
        drain();
        write_reg(CFG_WORKERS, workers);
        write_reg(CFG_SLOTS, slots);
        write_reg(CFG_TIMEOUT, timeout);
    endtask

    // Hand-picked cases at the reset settings
    task automatic test_directed();
        send_op(ACT_ADD, 3'd5, 16'h0000, 2'd3, 1'b0, 32'd100);
        send_op(ACT_ADD, 3'd0, 16'hFFFF, 2'd0, 1'b1, 32'd101);
        send_op(ACT_ADD, 3'd7, 16'hFFFF, 2'd1, 1'b0, 32'hFFFF_FFF0);
        send_op(ACT_REMOVE, 3'd0, 16'h0000, 2'd0, 1'b0, 32'd102);
        send_op(ACT_REMOVE, 3'd0, 16'h0000, 2'd0, 1'b0, 32'd103);
        send_op(ACT_SET, 3'd1, 16'hFFFF, 2'd3, 1'b0, 32'd104);
        send_op(ACT_SET, 3'd1, 16'hFFFF, 2'd0, 1'b0, 32'd105);
        send_op(ACT_SET, 3'd7, 16'hABCD, 2'd2, 1'b1, 32'd106);
        send_op(ACT_ADD, 3'd0, 16'h1234, 2'd0, 1'b0, 32'hFFFF_FFF8);
        send_op(ACT_ADD, 3'd0, 16'h4321, 2'd0, 1'b0, 32'hFFFF_FFFF);
        // age wraps through zero and just reaches the timeout
        send_op(ACT_SWEEP, 3'd0, 16'h5555, 2'd2, 1'b1, 32'd7);
        send_op(ACT_SWEEP, 3'd0, 16'h0000, 2'd0, 1'b0, 32'd14);
        send_op(ACT_SWEEP, 3'd5, 16'h0000, 2'd0, 1'b0, 32'd20);
        send_op(ACT_SET, 3'd2, 16'h4321, 2'd1, 1'b0, 32'd21);
        send_op(ACT_REMOVE, 3'd7, 16'hFFFF, 2'd3, 1'b1, 32'd22);
    endtask

    // Register clamping and timeout extremes
    task automatic test_registers();
        set_regs(32'd0, 32'd0, 32'd0);
        send_op(ACT_ADD, 3'd0, 16'h0A0A, 2'd0, 1'b0, 32'd50);
        send_op(ACT_ADD, 3'd0, 16'h0B0B, 2'd0, 1'b1, 32'd51);
        send_op(ACT_SWEEP, 3'd0, 16'h0000, 2'd0, 1'b0, 32'd50);
        set_regs(32'd15, 32'd31, 32'hFFFF_FFFF);
        send_op(ACT_ADD, 3'd0, 16'h0C0C, 2'd0, 1'b0, 32'd1);
        send_op(ACT_SWEEP, 3'd0, 16'h0000, 2'd0, 1'b0, 32'hFFFF_FFFF);
        send_op(ACT_SWEEP, 3'd0, 16'h0000, 2'd0, 1'b0, 32'd0);
        send_op(ACT_SWEEP, 3'd1, 16'h0000, 2'd0, 1'b0, 32'd0);
    endtask

    // Drive one worker's load past its ceiling with set-to-free
    task automatic test_load_limits();
        set_regs(32'd1, 32'd2, 32'd15);
        for (int k = 0; k < 36; k++) begin
            send_op(ACT_ADD, 3'd0, 16'h2000 + 16'(k), 2'd0, 1'b0, clock_now);
            send_op(ACT_SET, 3'd0, 16'h2000 + 16'(k), ST_FREE, 1'b0, clock_now);
        end
        send_op(ACT_ADD, 3'd0, 16'h3000, 2'd0, 1'b0, clock_now);
        send_op(ACT_REMOVE, 3'd0, 16'h3000, 2'd0, 1'b0, clock_now);
    endtask

    task automatic random_op();
        logic [1:0]  act;
        logic [2:0]  w;
        logic [3:0]  s;
        logic [15:0] sock;
        int          pick;
        pick = $urandom_range(0, 99);
        act = pick < 45 ? ACT_ADD : pick < 65 ? ACT_REMOVE : pick < 80 ? ACT_SET : ACT_SWEEP;
        if ($urandom_range(0, 7) == 0)
            w = 3'($urandom_range(0, 7));
        else
            w = 3'($urandom_range(0, active_workers() - 1));
        s = 4'($urandom_range(0, active_slots() - 1));
        if (act != ACT_ADD && slot_state[w][s] != ST_FREE && $urandom_range(0, 3) != 0)
            sock = slot_sock[w][s];
        else if ($urandom_range(0, 2) == 0)
            sock = 16'($urandom_range(0, 7));
        else
            sock = 16'($urandom);
        if ($urandom_range(0, 40) == 0) clock_now = $urandom;
        else clock_now += $urandom_range(0, 6);
        send_op(act, w, sock, 2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0, clock_now);
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        set_regs(32'd8, 32'd16, 32'd10);
        hold_go = 1'b1;
        for (int k = 0; k < 24; k++) random_op();
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_regs(32'd8, 32'd16, $urandom_range(5, 30));
                1: set_regs($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 40));
                2: set_regs(32'd3, 32'd4, 32'd6);
                default: set_regs($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 25));
            endcase
            quiet = (phase == 3);
            for (int k = 0; k < 60; k++) random_op();
        end
    endtask

    initial begin
        reg_workers = 4'd8;
        reg_slots = 5'd16;
        reg_timeout = 32'd15;
        for (int i = 0; i < NW; i++) begin
            load_count[i] = '0;
            for (int j = 0; j < NS; j++) begin
                slot_state[i][j] = ST_FREE;
                slot_sock[i][j] = '0;
                slot_stamp[i][j] = '0;
            end
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_registers();
        test_load_limits();
        test_backpressure();
        test_random();
        drain();
        if (fails == 0)
            $display("least_loaded_connection_table test passed");
        else
            $display("least_loaded_connection_table test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/llct_pkg.sv
hdl/llct_ram.sv
hdl/least_loaded_connection_table.sv
test/least_loaded_connection_table_tb.sv
